@@ rtl/dpm_pkg.sv @@
package dpm_pkg;

    localparam int MAG_W     = 16;
    localparam int FILL_W    = 17;
    localparam int TIME_W    = 10;
    localparam int CFG_W     = 16;
    localparam int DROP_W    = CFG_W + TIME_W;
    localparam int LOG_Q_W   = 16;
    localparam int ATTEN_W   = 20;
    localparam int QUOT_W    = 23;
    localparam int KDB_W     = 19;
    localparam int RECIP_SH  = 24;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [FILL_W-1:0] FULL_FILL       = 17'h10000;
    localparam logic [KDB_W-1:0]  DB_PER_LOG2_Q16 = 19'd394566;

    localparam logic [CFG_W-1:0] DECAY_RATE_RST = 16'd1092;
    localparam logic [CFG_W-1:0] HOLD_TIME_RST  = 16'd1000;

    // Word index of a configuration register (byte address bit 2).
    typedef enum logic {
        REG_DECAY_RATE = 1'b0,
        REG_HOLD_TIME  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [MAG_W-1:0]  in_left;
        logic [MAG_W-1:0]  in_right;
        logic [MAG_W-1:0]  out_left;
        logic [MAG_W-1:0]  out_right;
        logic [TIME_W-1:0] elapsed;
    } item_t;

    typedef struct packed {
        logic [FILL_W-1:0] in_level;
        logic [FILL_W-1:0] in_marker;
        logic [FILL_W-1:0] out_level;
        logic [FILL_W-1:0] out_marker;
    } result_t;

    // Load enables of the four conversion stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

    // log2(1 + f / 2^bits) in Q16 by repeated squaring; evaluated at elaboration only.
    function automatic logic [LOG_Q_W-1:0] mant_log(input int f, input int bits);
        logic [63:0]        x;
        logic [LOG_Q_W-1:0] r;
        x = (64'd1 << 30) + (64'(f) << (30 - bits));
        r = '0;
        for (int i = 0; i < LOG_Q_W; i++)
        begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd2 << 30))
            begin
                x = x >> 1;
                r = r | 16'd1;
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/dpm_db_map.sv @@
module dpm_db_map
    import dpm_pkg::*;
#(
    parameter int FLOOR_DB       = 60,
    parameter int LOG_TABLE_BITS = 6
)
(
    input  logic              clk,
    input  adv_t              adv,
    input  logic [MAG_W-1:0]  mag_a,
    input  logic [MAG_W-1:0]  mag_b,
    output logic [FILL_W-1:0] fill
);

    localparam int TBL_SIZE = 1 << LOG_TABLE_BITS;
    localparam int SHIFT_W  = (MAG_W - 1) + LOG_TABLE_BITS;
    localparam int RECIP    = (1 << RECIP_SH) / FLOOR_DB;
    localparam int REC_W    = $clog2(RECIP + 1);
    localparam int EST_W    = QUOT_W + REC_W - RECIP_SH;
    localparam int FL_W     = $clog2(FLOOR_DB + 1);
    localparam int REM_W    = QUOT_W + FL_W;
    localparam int D_W      = EST_W + 1;
    localparam logic [REC_W-1:0] RECIP_C = REC_W'(RECIP);
    localparam logic [FL_W-1:0]  FLOOR_C = FL_W'(FLOOR_DB);

    logic [LOG_Q_W-1:0] mant_rom [TBL_SIZE];

    for (genvar g = 0; g < TBL_SIZE; g++)
    begin : g_rom
        assign mant_rom[g] = mant_log(g, LOG_TABLE_BITS);
    end

    // Stage 1: louder channel, leading one, mantissa lookup, attenuation in log2 units.
    logic [MAG_W-1:0]          mag;
    logic [3:0]                lead;
    logic [SHIFT_W-1:0]        shifted;
    logic [LOG_TABLE_BITS-1:0] frac;
    logic [ATTEN_W-1:0]        atten;

    always_comb
    begin
        mag  = (mag_a > mag_b) ? mag_a : mag_b;
        lead = '0;
        for (int i = 0; i < MAG_W - 1; i++)
        begin
            if (mag[i])
            begin
                lead = 4'(i);
            end
        end
        shifted = {mag[MAG_W-2:0], {LOG_TABLE_BITS{1'b0}}} >> lead;
        frac    = shifted[LOG_TABLE_BITS-1:0];
        atten   = {4'd15 - lead, 16'd0} - {4'd0, mant_rom[frac]};
    end

    logic [ATTEN_W-1:0] atten_reg;
    logic               zero1_reg, full1_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            atten_reg <= atten;
            zero1_reg <= (mag == '0);
            full1_reg <= mag[MAG_W-1];
        end
    end

    // Stage 2: scale to dB over the floor, the power-of-two part of the divisor.
    logic [ATTEN_W+KDB_W-1:0] prod_db;
    logic [QUOT_W-1:0]        quot_reg;
    logic                     zero2_reg, full2_reg;

    assign prod_db = (ATTEN_W+KDB_W)'(atten_reg) * (ATTEN_W+KDB_W)'(DB_PER_LOG2_Q16);

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            quot_reg  <= prod_db[16 +: QUOT_W];
            zero2_reg <= zero1_reg;
            full2_reg <= full1_reg;
        end
    end

    // Stage 3: reciprocal estimate of the division by the floor; low by at most one.
    logic [QUOT_W+REC_W-1:0] prod_rec;
    logic [EST_W-1:0]        est_reg;
    logic [QUOT_W-1:0]       quot3_reg;
    logic                    zero3_reg, full3_reg;

    assign prod_rec = (QUOT_W+REC_W)'(quot_reg) * (QUOT_W+REC_W)'(RECIP_C);

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            est_reg   <= prod_rec[QUOT_W+REC_W-1:RECIP_SH];
            quot3_reg <= quot_reg;
            zero3_reg <= zero2_reg;
            full3_reg <= full2_reg;
        end
    end

    // Stage 4: correct the estimate and form the fill.
    logic [REM_W-1:0]  prod_fl;
    logic [REM_W-1:0]  rem;
    logic [D_W-1:0]    loss;
    logic [FILL_W-1:0] fill_c;
    logic [FILL_W-1:0] fill_reg;

    always_comb
    begin
        prod_fl = REM_W'(est_reg) * REM_W'(FLOOR_C);
        rem     = REM_W'(quot3_reg) - prod_fl;
        loss    = D_W'(est_reg) + D_W'(rem >= REM_W'(FLOOR_C));
        if (zero3_reg)
        begin
            fill_c = '0;
        end
        else if (full3_reg)
        begin
            fill_c = FULL_FILL;
        end
        else if (loss >= D_W'(FULL_FILL))
        begin
            fill_c = '0;
        end
        else
        begin
            fill_c = FILL_W'(D_W'(FULL_FILL) - loss);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            fill_reg <= fill_c;
        end
    end

    assign fill = fill_reg;

endmodule

@@ rtl/dpm_ballistics.sv @@
module dpm_ballistics
    import dpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update,
    input  logic [FILL_W-1:0] target,
    input  logic [DROP_W-1:0] drop,
    input  logic [TIME_W-1:0] elapsed,
    input  logic [CFG_W-1:0]  hold_time,
    output logic [FILL_W-1:0] level_next,
    output logic [FILL_W-1:0] marker_next
);

    logic [FILL_W-1:0] bar_reg, bar_next;
    logic [FILL_W-1:0] hold_pos_reg, hold_pos_next;
    logic [CFG_W-1:0]  hold_left_reg, hold_left_next;

    always_comb
    begin
        bar_next       = bar_reg;
        hold_pos_next  = hold_pos_reg;
        hold_left_next = hold_left_reg;

        if (target > bar_reg)
        begin
            bar_next = target;
        end
        else if (DROP_W'(bar_reg) > drop)
        begin
            bar_next = FILL_W'(DROP_W'(bar_reg) - drop);
        end
        else
        begin
            bar_next = '0;
        end

        // The marker holds while the timer runs and decays like the bar afterwards.
        if (target > hold_pos_reg)
        begin
            hold_pos_next  = target;
            hold_left_next = hold_time;
        end
        else if (hold_left_reg != '0)
        begin
            if (hold_left_reg > CFG_W'(elapsed))
            begin
                hold_left_next = hold_left_reg - CFG_W'(elapsed);
            end
            else
            begin
                hold_left_next = '0;
            end
        end
        else if (DROP_W'(hold_pos_reg) > drop)
        begin
            hold_pos_next = FILL_W'(DROP_W'(hold_pos_reg) - drop);
        end
        else
        begin
            hold_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_reg       <= '0;
            hold_pos_reg  <= '0;
            hold_left_reg <= '0;
        end
        else if (update)
        begin
            bar_reg       <= bar_next;
            hold_pos_reg  <= hold_pos_next;
            hold_left_reg <= hold_left_next;
        end
    end

    assign level_next  = bar_next;
    assign marker_next = hold_pos_next;

endmodule

@@ rtl/dual_peak_meter_with_hold.sv @@
// Dual peak meter with peak hold for an input pair and an output pair of channels.
// Each transaction on the item channel carries four linear peak magnitudes
// (32768 is full scale) and the milliseconds elapsed since the previous one.
// Each transaction on the result channel carries the bar fill and the hold
// marker of both pairs after that update, where 65536 means a full bar.
// Both channels use valid and stall; a transaction completes at a rising edge
// with valid high and stall low. Two lanes, one per pair, convert the louder
// channel to a dB fill in four register stages, and the output register merges
// the ballistics of both lanes into one result.
// A taken item moves through stages 1 to 4 into the output register. Throughput
// is one item per cycle while results are not stalled. Each stage holds while
// the one after it is full and stalled, so items are still taken into empty
// stages while a result waits; item_stall rises only if all five stages are full.
// Reset clears all bars, markers and hold timers, empties the pipeline, and
// sets decay_rate to 1092 and hold_time to 1000. The APB registers are
// decay_rate at byte address 0 and hold_time at byte address 4.
module dual_peak_meter_with_hold
    import dpm_pkg::*;
#(
    parameter int FLOOR_DB       = 60,
    parameter int LOG_TABLE_BITS = 6
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,

    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Configuration registers. The user changes them only while the meter is idle; the block does not enforce it.
    logic [CFG_W-1:0] decay_rate_reg;
    logic [CFG_W-1:0] hold_time_reg;
    reg_idx_t         reg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_rate_reg <= DECAY_RATE_RST;
            hold_time_reg  <= HOLD_TIME_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_DECAY_RATE: decay_rate_reg <= pwdata[CFG_W-1:0];
                REG_HOLD_TIME:  hold_time_reg  <= pwdata[CFG_W-1:0];
                default:        decay_rate_reg <= decay_rate_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DECAY_RATE: prdata = DATA_W'(decay_rate_reg);
            REG_HOLD_TIME:  prdata = DATA_W'(hold_time_reg);
            default:        prdata = '0;
        endcase
    end

    // Pipeline control. A stage loads when it is empty or its content moves on,
    // so bubbles close up even while the output register is stalled.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic out_valid_reg;
    logic load_out;
    adv_t adv;

    always_comb
    begin
        load_out = !out_valid_reg || !result_stall;
        adv.s4   = !v4_reg || load_out;
        adv.s3   = !v3_reg || adv.s4;
        adv.s2   = !v2_reg || adv.s3;
        adv.s1   = !v1_reg || adv.s2;
    end

    assign item_stall = !adv.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv.s1)
            begin
                v1_reg <= item_valid;
            end
            if (adv.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv.s4)
            begin
                v4_reg <= v3_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    // Decay step and elapsed time travel beside the lanes to the ballistics.
    logic [DROP_W-1:0] drop1_reg, drop2_reg, drop3_reg, drop4_reg;
    logic [TIME_W-1:0] dt1_reg, dt2_reg, dt3_reg, dt4_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            drop1_reg <= DROP_W'(decay_rate_reg) * DROP_W'(item.elapsed);
            dt1_reg   <= item.elapsed;
        end
        if (adv.s2)
        begin
            drop2_reg <= drop1_reg;
            dt2_reg   <= dt1_reg;
        end
        if (adv.s3)
        begin
            drop3_reg <= drop2_reg;
            dt3_reg   <= dt2_reg;
        end
        if (adv.s4)
        begin
            drop4_reg <= drop3_reg;
            dt4_reg   <= dt3_reg;
        end
    end

    // Lanes: input pair and output pair.
    logic [FILL_W-1:0] in_fill, out_fill;

    dpm_db_map #(
        .FLOOR_DB       (FLOOR_DB),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_in_map (
        .clk   (clk),
        .adv   (adv),
        .mag_a (item.in_left),
        .mag_b (item.in_right),
        .fill  (in_fill)
    );

    dpm_db_map #(
        .FLOOR_DB       (FLOOR_DB),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_out_map (
        .clk   (clk),
        .adv   (adv),
        .mag_a (item.out_left),
        .mag_b (item.out_right),
        .fill  (out_fill)
    );

    // Ballistics state advances exactly when an item enters the output register.
    logic              bal_update;
    logic [FILL_W-1:0] in_level_c, in_marker_c, out_level_c, out_marker_c;

    assign bal_update = load_out && v4_reg;

    dpm_ballistics u_in_bal (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (bal_update),
        .target      (in_fill),
        .drop        (drop4_reg),
        .elapsed     (dt4_reg),
        .hold_time   (hold_time_reg),
        .level_next  (in_level_c),
        .marker_next (in_marker_c)
    );

    dpm_ballistics u_out_bal (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (bal_update),
        .target      (out_fill),
        .drop        (drop4_reg),
        .elapsed     (dt4_reg),
        .hold_time   (hold_time_reg),
        .level_next  (out_level_c),
        .marker_next (out_marker_c)
    );

    // Output register: merges both lanes into one result transaction.
    result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (bal_update)
        begin
            result_reg.in_level   <= in_level_c;
            result_reg.in_marker  <= in_marker_c;
            result_reg.out_level  <= out_level_c;
            result_reg.out_marker <= out_marker_c;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // The item side stalls only when every stage holds an item behind a stalled result.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_valid_reg && result_stall))
        else $error("item stall with a free pipeline stage");

    // A stalled result stays valid and keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("result changed while stalled");

    // Hold markers never exceed full scale.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.in_marker <= FULL_FILL && result.out_marker <= FULL_FILL))
        else $error("fill above full scale");

    // A result appears only when a finished item sat in the last stage.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v4_reg))
        else $error("result without a finished item");

endmodule
